### src/sha1he_pkg.sv
package sha1he_pkg;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_R0 = 32'h5a827999;
	localparam logic [31:0] K_R1 = 32'h6ed9eba1;
	localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_R3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// one schedule word on its way to the compression core
	typedef struct packed {
		logic        last_blk;  // last word of the final block of a message
		logic [31:0] word;
	} qent_t;

endpackage

### src/sha1he_fifo.sv
module sha1he_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha1he_pkg::qent_t din,
	output logic              full,
	input  logic              pop,
	output sha1he_pkg::qent_t dout,
	output logic              empty
);
	import sha1he_pkg::*;

	qent_t           mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/sha1he_front.sv
module sha1he_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  logic              byte_present,
	input  logic              end_of_message,
	input  logic              push,
	output logic              full,
	output logic              q_push,
	output sha1he_pkg::qent_t q_data,
	input  logic              q_full
);
	import sha1he_pkg::*;

	localparam logic [3:0] LEN_HI_IDX = 4'd14;
	localparam logic [3:0] LEN_LO_IDX = 4'd15;

	logic [5:0]  fill_q;
	logic [31:0] word_q;
	logic [63:0] len_q;
	logic        pad_q;
	logic        pad_first_q;
	logic        lenblk_q;
	logic [3:0]  widx_q;

	logic        accept;
	logic [1:0]  lane;
	logic [4:0]  shamt;
	logic [31:0] base;
	logic [31:0] byte_word;
	logic [31:0] pad_word;
	logic [5:0]  fill_nx;
	logic        pad_done;

	assign full   = pad_q | q_full;
	assign accept = push & ~full;

	// bytes pack big-endian; lane 0 starts a fresh word
	assign lane      = fill_q[1:0];
	assign shamt     = {~lane, 3'b000};
	assign base      = (lane == 2'd0) ? 32'h0 : word_q;
	assign byte_word = base | ({24'h0, data_byte} << shamt);
	assign pad_word  = base | ({24'h0, PAD_BYTE} << shamt);
	assign fill_nx   = fill_q + {5'd0, byte_present};
	assign pad_done  = pad_q & ~q_full & ~pad_first_q & lenblk_q & (widx_q == LEN_LO_IDX);

	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		if (pad_q) begin
			q_push = ~q_full;
			if (pad_first_q) begin
				q_data.word = pad_word;
			end else if (lenblk_q && widx_q == LEN_HI_IDX) begin
				q_data.word = len_q[63:32];
			end else if (lenblk_q && widx_q == LEN_LO_IDX) begin
				q_data.word     = len_q[31:0];
				q_data.last_blk = 1'b1;
			end
		end else if (accept && byte_present && lane == 2'd3) begin
			q_push      = 1'b1;
			q_data.word = byte_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			word_q      <= '0;
			len_q       <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			lenblk_q    <= 1'b0;
			widx_q      <= '0;
		end else if (pad_q) begin
			if (!q_full) begin
				pad_first_q <= 1'b0;
				widx_q      <= widx_q + 1'b1;
				// length goes in the block whose words 14 and 15 are still free
				if (pad_first_q) begin
					lenblk_q <= (widx_q != LEN_HI_IDX);
				end else if (widx_q == LEN_LO_IDX) begin
					lenblk_q <= 1'b1;
				end
				if (pad_done) begin
					pad_q  <= 1'b0;
					fill_q <= '0;
					len_q  <= '0;
					word_q <= '0;
				end
			end
		end else if (accept) begin
			if (byte_present) begin
				fill_q <= fill_nx;
				len_q  <= len_q + 64'd8;
				word_q <= byte_word;
			end
			if (end_of_message) begin
				pad_q       <= 1'b1;
				pad_first_q <= 1'b1;
				lenblk_q    <= 1'b0;
				widx_q      <= fill_nx[5:2];
			end
		end
	end

endmodule

### src/sha1he_core.sv
module sha1he_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  sha1he_pkg::qent_t q_data,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha1he_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_OUT} state_t;

	localparam logic [6:0] LAST_LOAD  = 7'd15;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] LAST_OUT   = 7'd4;

	state_t      state_q;
	logic [6:0]  cnt_q;
	logic        last_q;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] w_x;
	logic [31:0] w_new;

	assign q_pop       = (state_q == ST_LOAD) & ~q_empty;
	assign empty       = (state_q != ST_OUT);
	assign word_index  = cnt_q[2:0];
	assign last_word   = (cnt_q == LAST_OUT);
	assign digest_word = h_q[cnt_q[2:0]];

	always_comb begin
		if (cnt_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_R0;
		end else if (cnt_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_R1;
		end else if (cnt_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_R2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_R3;
		end
	end

	// w_q[0] is W[t]; the window rolls one word per round
	assign w_x   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_x[30:0], w_x[31]};
	assign tmp   = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && !q_empty) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= q_data.word;
			if (cnt_q == LAST_LOAD) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			a_q     <= tmp;
			b_q     <= a_q;
			c_q     <= {b_q[1:0], b_q[31:2]};
			d_q     <= c_q;
			e_q     <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (!q_empty) begin
						if (cnt_q == LAST_LOAD) begin
							last_q  <= q_data.last_blk;
							cnt_q   <= '0;
							state_q <= ST_ROUND;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_ROUND: begin
					if (cnt_q == LAST_ROUND) begin
						cnt_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ADD: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					cnt_q   <= '0;
					state_q <= last_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (pop) begin
						if (cnt_q == LAST_OUT) begin
							for (int i = 0; i < 5; i++) begin
								h_q[i] <= H_INIT[i];
							end
							cnt_q   <= '0;
							last_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

### src/sha1_hash_engine.sv
// channel   direction  handshake       fields
// input     in         push / full     data_byte, byte_present, end_of_message
// result    out        empty / pop     digest_word, word_index, last_word
//
// A byte is taken per cycle while the word queue has room and no padding runs.
// Each 64-byte block costs 16 queue reads, 80 rounds and one chaining add in the
// single round unit; padding pushes one word per cycle while the queue has room.
// full stays high while padding words are generated and while the queue is full.
// The five digest words wait for pop; the next message can only fill the queue.
// Reset returns the chaining words to the initial constants and empties the queue.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        push,
	output logic        full,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        empty,
	input  logic        pop
);
	import sha1he_pkg::*;

	logic  f_push;
	qent_t f_data;
	logic  q_full;
	logic  c_pop;
	qent_t c_data;
	logic  q_empty;

	sha1he_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.push           (push),
		.full           (full),
		.q_push         (f_push),
		.q_data         (f_data),
		.q_full         (q_full)
	);

	sha1he_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_data),
		.full   (q_full),
		.pop    (c_pop),
		.dout   (c_data),
		.empty  (q_empty)
	);

	sha1he_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (c_pop),
		.q_data      (c_data),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

### test/sha1_digest_checker.sv
`timescale 1ns / 1ps

module sha1_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	input  logic        empty,
	input  logic        pop,
	output int          mismatches,
	output int          words_due
);
	import sha1he_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	digest_word_t digest_due [$];

	logic [31:0] chain [5];
	logic [31:0] sched [16];
	logic [5:0]  fill;
	logic [63:0] msg_bits;

	function automatic void clear_state();
		for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
		for (int i = 0; i < 16; i++) sched[i] = '0;
		fill = '0;
		msg_bits = '0;
	endfunction

	function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
		sched[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = b;
	endfunction

	// 80 rounds over the rolling 16-word schedule, then the chaining add
	function automatic void sha1_compress();
		logic [31:0] a, b, c, d, e, f, k, x, tmp;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				x = sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^ sched[(t + 2) % 16]
					^ sched[t % 16];
				sched[t % 16] = {x[30:0], x[31]};
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			tmp = {a[26:0], a[31:27]} + f + e + sched[t % 16] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = tmp;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		place_byte(fill, b);
		msg_bits += 64'd8;
		fill += 6'd1;
		if (fill == 6'd0)
			sha1_compress();
	endfunction

	function automatic void close_message();
		digest_word_t w;
		place_byte(fill, PAD_BYTE);
		for (int p = int'(fill) + 1; p < 64; p++)
			place_byte(6'(p), 8'h00);
		// no room for the length: spill into one more block
		if (fill >= 6'd56) begin
			sha1_compress();
			for (int i = 0; i < 16; i++) sched[i] = '0;
		end
		sched[14] = msg_bits[63:32];
		sched[15] = msg_bits[31:0];
		sha1_compress();
		for (int i = 0; i < 5; i++) begin
			w.word = chain[i];
			w.idx = 3'(i);
			w.last = (i == 4);
			digest_due.push_back(w);
		end
		clear_state();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_word_t w;
		if (!arst_n) begin
			clear_state();
			digest_due.delete();
		end else begin
			if (push && !full) begin
				if (byte_present)
					absorb_byte(data_byte);
				if (end_of_message)
					close_message();
			end
			if (pop && !empty) begin
				if (digest_due.size() == 0) begin
					$error("unexpected digest word %h (index %0d)", digest_word, word_index);
					mismatches++;
				end else begin
					w = digest_due.pop_front();
					if (digest_word !== w.word) begin
						$error("digest_word: expected %h, got %h", w.word, digest_word);
						mismatches++;
					end
					if (word_index !== w.idx) begin
						$error("word_index: expected %0d, got %0d", w.idx, word_index);
						mismatches++;
					end
					if (last_word !== w.last) begin
						$error("last_word: expected %b, got %b", w.last, last_word);
						mismatches++;
					end
				end
			end
		end
		words_due = digest_due.size();
	end

endmodule

### test/sha1_hash_engine_tb.sv
`timescale 1ns / 1ps

module sha1_hash_engine_tb;

	localparam int ITEM_TARGET    = 350;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        push;
	logic        full;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        empty;
	logic        pop;

	int mismatches;
	int words_due;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sha1_hash_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.push           (push),
		.full           (full),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word),
		.empty          (empty),
		.pop            (pop)
	);

	sha1_digest_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.push           (push),
		.full           (full),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word),
		.empty          (empty),
		.pop            (pop),
		.mismatches     (mismatches),
		.words_due      (words_due)
	);

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(8, 40);
		return $urandom_range(60, 150);
	endfunction

	// lengths cluster around the padding and block boundaries
	function automatic int pick_len();
		unique case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 20);
			4:          return $urandom_range(55, 57);
			5:          return $urandom_range(63, 65);
			6:          return $urandom_range(119, 121);
			7:          return $urandom_range(0, 130);
			8:          return 0;
			default:    return $urandom_range(1, 8);
		endcase
	endfunction

	// one input transfer, then an optional gap; ends on a falling edge
	task automatic put_item(input logic [7:0] b, input logic p, input logic e);
		int n;
		data_byte <= b;
		byte_present <= p;
		end_of_message <= e;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		if (p || e)
			items_sent++;
		n = pick_gap();
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_message(input int len);
		bit tail_apart;
		tail_apart = (len == 0) || ($urandom_range(0, 2) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			put_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !tail_apart);
		end
		if (tail_apart)
			put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		wait (words_due == 0);
		@(negedge clk);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle item, empty message, "abc", extremes, ignored bytes
		put_item(8'hff, 1'b0, 1'b0);
		put_item(8'h00, 1'b0, 1'b1);
		put_item(8'h61, 1'b1, 1'b0);
		put_item(8'h62, 1'b1, 1'b0);
		put_item(8'h63, 1'b1, 1'b1);
		put_item(8'hff, 1'b1, 1'b0);
		put_item(8'h00, 1'b1, 1'b0);
		put_item(8'ha5, 1'b0, 1'b0);
		put_item(8'h5a, 1'b0, 1'b0);
		put_item(8'hff, 1'b0, 1'b1);
		put_item(8'h80, 1'b1, 1'b1);
		put_item(8'h55, 1'b1, 1'b0);
		put_item(8'haa, 1'b1, 1'b1);
		put_item(8'h00, 1'b1, 1'b1);
		put_item(8'hff, 1'b1, 1'b1);
		drain_results();

		// receiver holds off while short messages keep coming
		calm = 1'b1;
		hold_req = 1'b1;
		for (int m = 0; m < 8; m++)
			send_message($urandom_range(0, 6));
		calm = 1'b0;
		drain_results();

		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			send_message(pick_len());
			if ($urandom_range(0, 14) == 0)
				drain_results();
		end
		calm = 1'b0;

		push <= 1'b0;
		wait (words_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
